[hdl/pts_pkg.sv]
// Shared types, operation codes and the microcode ROM of the task scheduler.
package pts_pkg;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_INSTALL  = 2'd0;
    localparam t_func FUNC_SLEEP    = 2'd1;
    localparam t_func FUNC_TICK     = 2'd2;
    localparam t_func FUNC_SCHEDULE = 2'd3;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_INSTALL,
        ACT_SLEEP,
        ACT_TIME_INC,
        ACT_SCAN_INIT,
        ACT_SCAN,
        ACT_PICK,
        ACT_EMIT
    } t_act;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_LOOP
    } t_jmp;

    typedef logic [3:0] t_upc;

    localparam t_upc UPC_WAIT       = 4'd0;
    localparam t_upc UPC_INSTALL    = 4'd1;
    localparam t_upc UPC_EMIT       = 4'd2;
    localparam t_upc UPC_SLEEP      = 4'd3;
    localparam t_upc UPC_SCHED      = 4'd4;
    localparam t_upc UPC_SCHED_SCAN = 4'd5;
    localparam t_upc UPC_TICK       = 4'd6;
    localparam t_upc UPC_TICK_INIT  = 4'd7;
    localparam t_upc UPC_TICK_SCAN  = 4'd8;
    localparam t_upc UPC_PICK       = 4'd9;

    typedef struct packed {
        t_act act;
        logic scan_tick;   // scan wakes sleepers instead of ranking priorities
        t_jmp jmp;
        t_upc target;
    } t_uword;

    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword uw;
        case (pc)
            UPC_WAIT:       uw = '{ACT_NOP,       1'b0, JMP_DISPATCH, UPC_WAIT};
            UPC_INSTALL:    uw = '{ACT_INSTALL,   1'b0, JMP_GOTO,     UPC_EMIT};
            UPC_EMIT:       uw = '{ACT_EMIT,      1'b0, JMP_GOTO,     UPC_WAIT};
            UPC_SLEEP:      uw = '{ACT_SLEEP,     1'b0, JMP_NEXT,     UPC_WAIT};
            UPC_SCHED:      uw = '{ACT_SCAN_INIT, 1'b0, JMP_NEXT,     UPC_WAIT};
            UPC_SCHED_SCAN: uw = '{ACT_SCAN,      1'b0, JMP_LOOP,     UPC_PICK};
            UPC_TICK:       uw = '{ACT_TIME_INC,  1'b1, JMP_NEXT,     UPC_WAIT};
            UPC_TICK_INIT:  uw = '{ACT_SCAN_INIT, 1'b1, JMP_NEXT,     UPC_WAIT};
            UPC_TICK_SCAN:  uw = '{ACT_SCAN,      1'b1, JMP_LOOP,     UPC_EMIT};
            UPC_PICK:       uw = '{ACT_PICK,      1'b0, JMP_GOTO,     UPC_EMIT};
            default:        uw = '{ACT_NOP,       1'b0, JMP_GOTO,     UPC_WAIT};
        endcase
        return uw;
    endfunction

endpackage

[hdl/pts_useq.sv]
// Microcode sequencer: step counter, ROM lookup and jump logic.
module pts_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pts_pkg::t_func    i_func,
    input  logic              i_scan_busy,
    output pts_pkg::t_uword   o_uword,
    output logic              busy
);
    import pts_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;

    assign uw      = ucode_rom(r_pc);
    assign o_uword = uw;
    assign busy    = (r_pc != UPC_WAIT);

    always_comb begin
        n_pc = r_pc;
        case (uw.jmp)
            JMP_NEXT: begin
                n_pc = r_pc + t_upc'(1);
            end
            JMP_GOTO: begin
                n_pc = uw.target;
            end
            JMP_DISPATCH: begin
                if (start) begin
                    case (i_func)
                        FUNC_INSTALL:  n_pc = UPC_INSTALL;
                        FUNC_SLEEP:    n_pc = UPC_SLEEP;
                        FUNC_TICK:     n_pc = UPC_TICK;
                        FUNC_SCHEDULE: n_pc = UPC_SCHED;
                        default:       n_pc = UPC_WAIT;
                    endcase
                end
            end
            JMP_LOOP: begin
                // hold on the scan step until the last entry is evaluated
                n_pc = i_scan_busy ? r_pc : uw.target;
            end
            default: begin
                n_pc = UPC_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hdl/priority_task_scheduler_top.sv]
// Top level of the fixed-priority task scheduler: task table and scan datapath.
//
// Usage: present i_func, i_prio and i_delay_ticks with start high; the item is
// taken at a rising edge where start is high and busy is low. Exactly one
// result follows per item: o_valid is high for one cycle with o_task_index,
// o_woke_any and o_table_full. The receiver cannot stall; results must be
// taken in the cycle they appear.
// Steps from the accepting edge to the result, N = installed tasks:
//   install: store the entry, then emit
//   tick:    advance the time, scan the N entries to wake sleepers, emit
//   sched:   scan the N entries, pick the highest ready priority, emit;
//   sleep:   put the current task to sleep, then the sched steps
// Each scan reads one table entry per cycle through the single registered read
// port of the priority and wake-time memories and evaluates it after its read.
// busy drops in the cycle the result shows, so the next item may be accepted
// while the result is on the ports.
// Reset clears the ready bits, task count, current task and tick counter;
// the priority and wake-time memories keep their contents and are only read
// for installed entries.
module priority_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pts_pkg::t_func       i_func,
    input  logic [7:0]           i_prio,
    input  logic [31:0]          i_delay_ticks,
    output logic                 o_valid,
    output logic [3:0]           o_task_index,
    output logic                 o_woke_any,
    output logic                 o_table_full
);
    import pts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_uword uw;
    logic   accept;
    logic   scan_busy;
    logic   issue;
    logic   tbl_full;

    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_cur;
    logic [63:0]          r_time;
    logic [MAX_TASKS-1:0] r_ready;

    logic [7:0]  r_prio_in;
    logic [31:0] r_dly;

    logic [7:0]  r_prio_mem [MAX_TASKS];
    logic [63:0] r_wake_mem [MAX_TASKS];
    logic [7:0]  r_prio_rd;
    logic [63:0] r_wake_rd;
    logic [63:0] wake_sum;

    logic [CW-1:0] r_addr;
    logic          r_pend;
    logic [IW-1:0] r_pidx;
    logic [7:0]    r_best_prio;
    logic [IW-1:0] r_best_idx;
    logic          r_woke;
    logic          r_full;

    pts_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_func      (i_func),
        .i_scan_busy (scan_busy),
        .o_uword     (uw),
        .busy        (busy)
    );

    assign accept    = start && !busy;
    assign issue     = (r_addr < r_count);
    assign scan_busy = issue || r_pend;
    assign tbl_full  = (r_count == CW'(MAX_TASKS));
    assign wake_sum  = r_time + 64'(r_dly);

    // operands of the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prio_in <= i_prio;
            r_dly     <= i_delay_ticks;
        end
    end

    // task table memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (uw.act == ACT_INSTALL && !tbl_full) begin
            r_prio_mem[r_count[IW-1:0]] <= r_prio_in;
            r_wake_mem[r_count[IW-1:0]] <= '0;
        end else if (uw.act == ACT_SLEEP) begin
            r_wake_mem[r_cur] <= wake_sum;
        end
        if (uw.act == ACT_SCAN && issue) begin
            r_prio_rd <= r_prio_mem[r_addr[IW-1:0]];
            r_wake_rd <= r_wake_mem[r_addr[IW-1:0]];
        end
    end

    // control state, scan and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur       <= '0;
            r_time      <= '0;
            r_ready     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_pidx      <= '0;
            r_best_prio <= '0;
            r_best_idx  <= '0;
            r_woke      <= 1'b0;
            r_full      <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= (uw.act == ACT_EMIT);
            if (accept) begin
                r_woke <= 1'b0;
                r_full <= 1'b0;
            end
            case (uw.act)
                ACT_INSTALL: begin
                    if (tbl_full) begin
                        r_full <= 1'b1;
                    end else begin
                        r_ready[r_count[IW-1:0]] <= 1'b1;
                        r_count                  <= r_count + CW'(1);
                    end
                end
                ACT_SLEEP: begin
                    r_ready[r_cur] <= 1'b0;
                end
                ACT_TIME_INC: begin
                    r_time <= r_time + 64'd1;
                end
                ACT_SCAN_INIT: begin
                    r_addr      <= '0;
                    r_pend      <= 1'b0;
                    r_best_prio <= '0;
                    r_best_idx  <= '0;
                end
                ACT_SCAN: begin
                    // evaluate the entry read last cycle while the next read issues
                    if (r_pend) begin
                        if (uw.scan_tick) begin
                            if (!r_ready[r_pidx] && r_wake_rd <= r_time) begin
                                r_ready[r_pidx] <= 1'b1;
                                r_woke          <= 1'b1;
                            end
                        end else if (r_ready[r_pidx] && r_prio_rd > r_best_prio) begin
                            r_best_prio <= r_prio_rd;
                            r_best_idx  <= r_pidx;
                        end
                    end
                    if (issue) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_addr[IW-1:0];
                        r_addr <= r_addr + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                ACT_PICK: begin
                    r_cur <= r_best_idx;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.act == ACT_EMIT) begin
            o_task_index <= 4'(r_cur);
            o_woke_any   <= r_woke;
            o_table_full <= r_full;
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count beyond table size");

    a_cur_installed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == '0) || (CW'(r_cur) < r_count))
        else $error("current task is not an installed entry");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (r_count == CW'(MAX_TASKS)))
        else $error("install refused while table had room");
`endif

endmodule
